FILE: src/mpps_pkg.sv
// Shared types and constants of the marker pair proportion scorer.
package mpps_pkg;

    localparam int SLOT_W   = 12;
    localparam int EXPR_W   = 32;
    localparam int CNT_W    = 16;
    localparam int PROP_W   = 17;
    localparam int VERD_W   = 2;
    localparam int IN_DW    = 56;
    localparam int OUT_DW   = 40;
    localparam int CFG_IW   = 2;
    localparam int CFG_DW   = 17;
    localparam int PROD_W   = 34;

    localparam logic [PROP_W-1:0] Q_ONE = 17'h10000;

    // Verdict codes carried on the result tuser.
    localparam logic [VERD_W-1:0] V_PROP  = 2'd0;
    localparam logic [VERD_W-1:0] V_BELOW = 2'd1;
    localparam logic [VERD_W-1:0] V_ABOVE = 2'd2;
    localparam logic [VERD_W-1:0] V_FEW   = 2'd3;

    // Configuration register indexes.
    localparam logic [CFG_IW-1:0] CFG_PAIR_COUNT = 2'd0;
    localparam logic [CFG_IW-1:0] CFG_MIN_PAIRS  = 2'd1;
    localparam logic [CFG_IW-1:0] CFG_THR_MODE   = 2'd2;
    localparam logic [CFG_IW-1:0] CFG_THRESHOLD  = 2'd3;

    // Queue between the front and back parts.
    localparam int Q_DEPTH = 4;
    localparam int Q_AW    = 2;

    typedef struct packed {
        logic [CNT_W-1:0]  pair_count;
        logic [CNT_W-1:0]  min_pairs;
        logic              thr_mode;
        logic [PROP_W-1:0] threshold;
    } t_cfg;

    // Outcome of one pair comparison.
    typedef struct packed {
        logic ne;
        logic gt;
    } t_pair_cls;

    typedef struct packed {
        logic [VERD_W-1:0] verdict;
        logic              early;
        logic [CNT_W-1:0]  nontie;
        logic [PROP_W-1:0] proportion;
    } t_result;

endpackage

FILE: src/mpps_front.sv
// Front part: slot store, load writes, pair reads and pair classification.
module mpps_front #(
    parameter int SLOTS = 4096
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    output logic                        o_ready,
    input  logic                        i_func,
    input  logic [mpps_pkg::SLOT_W-1:0] i_slot_first,
    input  logic [mpps_pkg::SLOT_W-1:0] i_slot_second,
    input  logic [mpps_pkg::EXPR_W-1:0] i_expr_value,
    output logic                        o_push,
    output mpps_pkg::t_pair_cls         o_cls,
    input  logic                        i_q_full
);
    import mpps_pkg::*;

    localparam int SW = (SLOTS > 1) ? $clog2(SLOTS) : 1;

    // Slot number modulo SLOTS by binary-weighted conditional subtraction.
    function automatic logic [SW-1:0] reduce_slot(input logic [SLOT_W-1:0] s);
        logic [SLOT_W-1:0] v;
        int unsigned       lim;
        v = s;
        for (int k = SLOT_W - 1; k >= 0; k--) begin
            lim = SLOTS << k;
            if (lim < (1 << SLOT_W)) begin
                if ({20'b0, v} >= lim) begin
                    v = v - lim[SLOT_W-1:0];
                end
            end
        end
        return SW'(v);
    endfunction

    logic [EXPR_W-1:0] r_mem [SLOTS];
    logic [EXPR_W-1:0] r_a;
    logic [EXPR_W-1:0] r_b;
    logic              r_vld;
    logic              adv;
    logic              acc;
    logic [SW-1:0]     addr_a;
    logic [SW-1:0]     addr_b;

    assign addr_a  = reduce_slot(i_slot_first);
    assign addr_b  = reduce_slot(i_slot_second);
    assign adv     = !r_vld || !i_q_full;
    assign o_ready = adv;
    assign acc     = i_valid && adv;

    always_ff @(posedge i_clk) begin
        if (acc) begin
            if (i_func) begin
                r_a <= r_mem[addr_a];
                r_b <= r_mem[addr_b];
            end else begin
                r_mem[addr_a] <= i_expr_value;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (adv) begin
            r_vld <= acc && i_func;
        end
    end

    assign o_push   = r_vld && !i_q_full;
    assign o_cls.ne = (r_a != r_b);
    assign o_cls.gt = ($signed(r_a) > $signed(r_b));

endmodule

FILE: src/mpps_queue.sv
// Short queue of classified pairs between the front and back parts.
module mpps_queue (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_push,
    input  mpps_pkg::t_pair_cls i_data,
    output logic                o_full,
    input  logic                i_pop,
    output mpps_pkg::t_pair_cls o_data,
    output logic                o_empty
);
    import mpps_pkg::*;

    t_pair_cls       r_ent [Q_DEPTH];
    logic [Q_AW:0]   r_wp;
    logic [Q_AW:0]   r_rp;

    assign o_empty = (r_wp == r_rp);
    assign o_full  = (r_wp[Q_AW] != r_rp[Q_AW]) && (r_wp[Q_AW-1:0] == r_rp[Q_AW-1:0]);
    assign o_data  = r_ent[r_rp[Q_AW-1:0]];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_ent[r_wp[Q_AW-1:0]] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp <= '0;
            r_rp <= '0;
        end else begin
            if (i_push) begin
                r_wp <= r_wp + 1'b1;
            end
            if (i_pop) begin
                r_rp <= r_rp + 1'b1;
            end
        end
    end

endmodule

FILE: src/mpps_back.sv
// Back part: run counters, early threshold check, final division and result register.
module mpps_back #(
    parameter int CHECK_INTERVAL = 100
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  mpps_pkg::t_cfg      i_cfg,
    input  mpps_pkg::t_pair_cls i_cls,
    input  logic                i_q_empty,
    output logic                o_pop,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output mpps_pkg::t_result   o_out
);
    import mpps_pkg::*;

    localparam int CMW = (CHECK_INTERVAL > 1) ? $clog2(CHECK_INTERVAL) : 1;
    localparam logic [CMW-1:0] MOD_TOP = CMW'(CHECK_INTERVAL - 1);

    localparam logic [2:0] S_PAIR = 3'd0;
    localparam logic [2:0] S_MUL  = 3'd1;
    localparam logic [2:0] S_CMP  = 3'd2;
    localparam logic [2:0] S_DIV  = 3'd3;
    localparam logic [2:0] S_FIN  = 3'd4;

    logic [2:0]        r_state, n_state;
    logic [CNT_W-1:0]  r_g, n_g;
    logic [CNT_W-1:0]  r_t, n_t;
    logic [CMW-1:0]    r_tmod, n_tmod;
    logic [CNT_W-1:0]  r_pos, n_pos;
    logic              r_dec, n_dec;
    logic              r_last, n_last;
    logic [CNT_W-1:0]  r_left, n_left;
    logic [PROD_W-1:0] r_prod, n_prod;
    logic [PROP_W-1:0] r_rem, n_rem;
    logic [PROP_W-1:0] r_quo, n_quo;
    logic [4:0]        r_cnt, n_cnt;
    logic              r_out_valid, n_out_valid;
    t_result           r_out, n_out;

    logic [CNT_W-1:0]  pc;
    logic [CNT_W:0]    pos_inc;
    logic              last;
    logic              g_up;
    logic              t_up;
    logic [CNT_W-1:0]  g_n;
    logic [CNT_W-1:0]  t_n;
    logic [CMW-1:0]    tmod_n;
    logic              chk;
    logic              out_free;
    logic [CNT_W:0]    maxt;
    logic [CNT_W:0]    mop;
    logic [CNT_W+1:0]  best;
    logic              v_below;
    logic              v_above;
    logic              below;
    logic              ge;
    logic [PROP_W-1:0] diff;

    always_comb begin
        pc      = (i_cfg.pair_count == '0) ? CNT_W'(1) : i_cfg.pair_count;
        pos_inc = {1'b0, r_pos} + (CNT_W+1)'(1);
        last    = pos_inc >= {1'b0, pc};
        g_up    = i_cls.ne && i_cls.gt && (r_g != '1);
        t_up    = i_cls.ne && (r_t != '1);
        g_n     = r_g + CNT_W'(g_up);
        t_n     = r_t + CNT_W'(t_up);
        if (t_up) begin
            tmod_n = (r_tmod == MOD_TOP) ? '0 : r_tmod + 1'b1;
        end else begin
            tmod_n = r_tmod;
        end
        chk      = i_cfg.thr_mode && (t_n >= i_cfg.min_pairs) && (tmod_n == '0);
        out_free = !r_out_valid || i_out_ready;
        maxt     = {1'b0, r_t} + {1'b0, r_left};
        mop      = r_last ? {1'b0, r_t} : maxt;
        // Bounds on the final score from the pairs still to come.
        best     = {2'b0, r_g} + {2'b0, r_left} + (CNT_W+2)'(1);
        v_below  = {best, 16'b0} < r_prod;
        v_above  = (r_g != '0) && ({2'b0, r_g - CNT_W'(1), 16'b0} > r_prod);
        below    = (r_t != '0) && ({2'b0, r_g, 16'b0} < r_prod);
        ge       = r_rem >= {1'b0, r_t};
        diff     = ge ? r_rem - {1'b0, r_t} : r_rem;

        n_state     = r_state;
        n_g         = r_g;
        n_t         = r_t;
        n_tmod      = r_tmod;
        n_pos       = r_pos;
        n_dec       = r_dec;
        n_last      = r_last;
        n_left      = r_left;
        n_prod      = r_prod;
        n_rem       = r_rem;
        n_quo       = r_quo;
        n_cnt       = r_cnt;
        n_out_valid = r_out_valid && !i_out_ready;
        n_out       = r_out;
        o_pop       = 1'b0;

        unique case (r_state)
            S_PAIR: begin
                if (!i_q_empty) begin
                    o_pop = 1'b1;
                    if (r_dec) begin
                        if (last) begin
                            n_g    = '0;
                            n_t    = '0;
                            n_tmod = '0;
                            n_pos  = '0;
                            n_dec  = 1'b0;
                        end else begin
                            n_pos = pos_inc[CNT_W-1:0];
                        end
                    end else begin
                        n_g    = g_n;
                        n_t    = t_n;
                        n_tmod = tmod_n;
                        if (last || chk) begin
                            n_last  = last;
                            n_left  = pc - r_pos - CNT_W'(1);
                            n_state = S_MUL;
                        end else begin
                            n_pos = pos_inc[CNT_W-1:0];
                        end
                    end
                end
            end
            S_MUL: begin
                n_prod  = i_cfg.threshold * mop;
                n_state = S_CMP;
            end
            S_CMP: begin
                if (out_free) begin
                    n_out.proportion = '0;
                    n_out.nontie     = r_t;
                    n_out.early      = !r_last;
                    if (r_last) begin
                        n_state = S_PAIR;
                        priority if (r_t < i_cfg.min_pairs) begin
                            n_out.verdict = V_FEW;
                            n_out_valid   = 1'b1;
                        end else if (i_cfg.thr_mode) begin
                            n_out.verdict = below ? V_BELOW : V_ABOVE;
                            n_out_valid   = 1'b1;
                        end else if (r_t == '0) begin
                            n_out.verdict = V_PROP;
                            n_out_valid   = 1'b1;
                        end else begin
                            n_rem   = {1'b0, r_g};
                            n_quo   = '0;
                            n_cnt   = '0;
                            n_state = S_DIV;
                        end
                        if (n_state == S_PAIR) begin
                            n_g    = '0;
                            n_t    = '0;
                            n_tmod = '0;
                            n_pos  = '0;
                            n_dec  = 1'b0;
                        end
                    end else begin
                        if (v_below || v_above) begin
                            n_out.verdict = v_below ? V_BELOW : V_ABOVE;
                            n_out_valid   = 1'b1;
                            n_dec         = 1'b1;
                        end
                        n_pos   = pos_inc[CNT_W-1:0];
                        n_state = S_PAIR;
                    end
                end
            end
            S_DIV: begin
                // One quotient bit per cycle, most significant first.
                n_quo = {r_quo[PROP_W-2:0], ge};
                n_rem = {diff[PROP_W-2:0], 1'b0};
                n_cnt = r_cnt + 1'b1;
                if (r_cnt == 5'(PROP_W - 1)) begin
                    n_state = S_FIN;
                end
            end
            S_FIN: begin
                if (out_free) begin
                    n_out.verdict    = V_PROP;
                    n_out.proportion = r_quo;
                    n_out.nontie     = r_t;
                    n_out.early      = 1'b0;
                    n_out_valid      = 1'b1;
                    n_g              = '0;
                    n_t              = '0;
                    n_tmod           = '0;
                    n_pos            = '0;
                    n_dec            = 1'b0;
                    n_state          = S_PAIR;
                end
            end
            default: begin
                n_state = S_PAIR;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_PAIR;
            r_g         <= '0;
            r_t         <= '0;
            r_tmod      <= '0;
            r_pos       <= '0;
            r_dec       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_g         <= n_g;
            r_t         <= n_t;
            r_tmod      <= n_tmod;
            r_pos       <= n_pos;
            r_dec       <= n_dec;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_last <= n_last;
        r_left <= n_left;
        r_prod <= n_prod;
        r_rem  <= n_rem;
        r_quo  <= n_quo;
        r_cnt  <= n_cnt;
        r_out  <= n_out;
    end

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

endmodule

FILE: src/marker_pair_proportion_score.sv
// Top level of the marker pair proportion scorer: configuration registers and stream ports.
//
// Load items write a 32-bit expression key into the slot store and pair items
// compare two stored slots; the front part takes one item per cycle while the
// queue is not full and reads both slots of a pair together from the two read
// ports of the store. A four-entry queue hands the pair outcomes to the back
// part. A pair that triggers a threshold check passes through a multiply and
// then a compare step, as does the last pair of a run, which in proportion
// mode, when a quotient is due, then forms it one bit per cycle. A result waits
// in an output register, so the next items keep flowing while it is not yet
// taken. Reading a slot that was never loaded gives an undefined score. The
// user must write configuration only while the block is idle; the block does
// not enforce this, and the configuration port is always ready.
module marker_pair_proportion_score #(
    parameter int SLOTS          = 4096,
    parameter int CHECK_INTERVAL = 100
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_s_tvalid,
    output logic                        o_s_tready,
    // slot_first[11:0], slot_second[23:12], expr_value[55:24]
    input  logic [mpps_pkg::IN_DW-1:0]  i_s_tdata,
    // func[0]
    input  logic                        i_s_tuser,
    output logic                        o_m_tvalid,
    input  logic                        i_m_tready,
    // proportion[16:0], nontie_count[32:17], decided_early[33], zero[39:34]
    output logic [mpps_pkg::OUT_DW-1:0] o_m_tdata,
    // verdict[1:0]
    output logic [mpps_pkg::VERD_W-1:0] o_m_tuser,
    input  logic                        i_cfg_valid,
    output logic                        o_cfg_ready,
    input  logic [mpps_pkg::CFG_IW-1:0] i_cfg_index,
    input  logic [mpps_pkg::CFG_DW-1:0] i_cfg_data
);
    import mpps_pkg::*;

    t_cfg      r_cfg;
    t_pair_cls cls_in;
    t_pair_cls cls_out;
    t_result   res;
    logic      push;
    logic      q_full;
    logic      q_empty;
    logic      pop;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.pair_count <= CNT_W'(1);
            r_cfg.min_pairs  <= '0;
            r_cfg.thr_mode   <= 1'b0;
            r_cfg.threshold  <= '0;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_PAIR_COUNT: r_cfg.pair_count <= i_cfg_data[CNT_W-1:0];
                CFG_MIN_PAIRS:  r_cfg.min_pairs  <= i_cfg_data[CNT_W-1:0];
                CFG_THR_MODE:   r_cfg.thr_mode   <= i_cfg_data[0];
                CFG_THRESHOLD:  r_cfg.threshold  <= i_cfg_data[PROP_W-1:0];
            endcase
        end
    end

    mpps_front #(
        .SLOTS(SLOTS)
    ) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_s_tvalid),
        .o_ready      (o_s_tready),
        .i_func       (i_s_tuser),
        .i_slot_first (i_s_tdata[11:0]),
        .i_slot_second(i_s_tdata[23:12]),
        .i_expr_value (i_s_tdata[55:24]),
        .o_push       (push),
        .o_cls        (cls_in),
        .i_q_full     (q_full)
    );

    mpps_queue u_queue (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_push (push),
        .i_data (cls_in),
        .o_full (q_full),
        .i_pop  (pop),
        .o_data (cls_out),
        .o_empty(q_empty)
    );

    mpps_back #(
        .CHECK_INTERVAL(CHECK_INTERVAL)
    ) u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg      (r_cfg),
        .i_cls      (cls_out),
        .i_q_empty  (q_empty),
        .o_pop      (pop),
        .o_out_valid(o_m_tvalid),
        .i_out_ready(i_m_tready),
        .o_out      (res)
    );

    assign o_m_tdata = {6'b0, res.early, res.nontie, res.proportion};
    assign o_m_tuser = res.verdict;

endmodule

FILE: src/mpps_checker.sv
// Port-level checks on the result stream of the scorer, bound to the top level.
module mpps_checker (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_m_tvalid,
    input  logic                        i_m_tready,
    input  logic [mpps_pkg::OUT_DW-1:0] i_m_tdata,
    input  logic [mpps_pkg::VERD_W-1:0] i_m_tuser
);
    import mpps_pkg::*;

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_m_tvalid && !i_m_tready |=>
            i_m_tvalid && $stable(i_m_tdata) && $stable(i_m_tuser))
        else $error("result changed while stalled");

    a_early_verdict: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_m_tvalid && i_m_tdata[33] |-> (i_m_tuser == V_BELOW || i_m_tuser == V_ABOVE))
        else $error("early decision without a threshold verdict");

    a_prop_only: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_m_tvalid && (i_m_tuser != V_PROP) |-> (i_m_tdata[16:0] == '0))
        else $error("proportion given with a threshold or too-few verdict");

    a_prop_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_m_tvalid |-> (i_m_tdata[16:0] <= Q_ONE) && (i_m_tdata[39:34] == '0))
        else $error("proportion above one or padding set");

endmodule

bind marker_pair_proportion_score mpps_checker u_mpps_checker (
    .i_clk     (i_clk),
    .i_rst_n   (i_rst_n),
    .i_m_tvalid(o_m_tvalid),
    .i_m_tready(i_m_tready),
    .i_m_tdata (o_m_tdata),
    .i_m_tuser (o_m_tuser)
);
